### rtl/rtc_pkg.sv
// shared types, constants and helpers of the region table carve block
// no dependencies; used by every other file of the block but rtc_ram
`default_nettype none

package rtc_pkg;

	localparam int MAX_REGIONS_DEF = 64;
	localparam int PAGE_W          = 32;
	localparam int TYPE_W          = 3;
	localparam int IDX_IN_W        = 6;
	localparam int COUNT_OUT_W     = 7;
	localparam int ENTRY_W         = 2 * PAGE_W + TYPE_W;
	localparam int IN_DATA_W       = 80;
	localparam int OUT_DATA_W      = 80;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_CARVE  = 2'd1,
		OP_READ   = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_RETYPED   = 3'd1,
		ST_SPLIT     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_BAD       = 3'd5
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    accept;
		logic    append;
		logic    rd_issue;
		logic    cap_entry;
		logic    scan_start;
		logic    scan_next;
		logic    hit_latch;
		logic    retype_wr;
		logic    shift_begin;
		logic    shift_step;
		logic    wr_head;
		logic    wr_mid;
		logic    wr_tail;
		logic    grow;
		logic    set_status;
		status_t status;
		logic    publish;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic bad_req;
		logic is_append;
		logic is_read;
		logic full_append;
		logic idx_ok;
		logic count_zero;
		logic hit;
		logic scan_more;
		logic head_nz;
		logic tail_nz;
		logic tail_oob;
		logic split_full;
		logic shift_more;
		logic out_busy;
	} dp_sts_t;

	function automatic logic [ENTRY_W-1:0] pack_entry(
		input logic [PAGE_W-1:0] base,
		input logic [PAGE_W-1:0] pages,
		input logic [TYPE_W-1:0] kind
	);
		return {kind, pages, base};
	endfunction

endpackage

`default_nettype wire

### rtl/rtc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/rtc_ctrl.sv
// controller state machine of the region table carve block
// depends on rtc_pkg for the command and status structs
`default_nettype none

module rtc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output rtc_pkg::dp_cmd_t      cmd,
	input  wire rtc_pkg::dp_sts_t sts
);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_DECODE  = 10'b00_0000_0010,
		S_RDDATA  = 10'b00_0000_0100,
		S_SCAN    = 10'b00_0000_1000,
		S_DECIDE  = 10'b00_0001_0000,
		S_SHIFT   = 10'b00_0010_0000,
		S_WR_HEAD = 10'b00_0100_0000,
		S_WR_MID  = 10'b00_1000_0000,
		S_WR_TAIL = 10'b01_0000_0000,
		S_RESP    = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = rtc_pkg::ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				state_d        = S_RESP;
				priority if (sts.bad_req) begin
					cmd.status = rtc_pkg::ST_BAD;
				end else if (sts.is_append) begin
					if (sts.full_append) begin
						cmd.status = rtc_pkg::ST_FULL;
					end else begin
						cmd.append = 1'b1;
						cmd.status = rtc_pkg::ST_DONE;
					end
				end else if (sts.is_read) begin
					if (sts.idx_ok) begin
						cmd.set_status = 1'b0;
						cmd.rd_issue   = 1'b1;
						state_d        = S_RDDATA;
					end else begin
						cmd.status = rtc_pkg::ST_NOT_FOUND;
					end
				end else begin
					if (sts.count_zero) begin
						cmd.status = rtc_pkg::ST_NOT_FOUND;
					end else begin
						cmd.set_status = 1'b0;
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_RDDATA: begin
				cmd.cap_entry  = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = rtc_pkg::ST_DONE;
				state_d        = S_RESP;
			end
			S_SCAN: begin
				priority if (sts.hit) begin
					cmd.hit_latch = 1'b1;
					state_d       = S_DECIDE;
				end else if (sts.scan_more) begin
					cmd.scan_next = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = rtc_pkg::ST_NOT_FOUND;
					state_d        = S_RESP;
				end
			end
			S_DECIDE: begin
				cmd.set_status = 1'b1;
				state_d        = S_RESP;
				priority if (!sts.head_nz && !sts.tail_nz) begin
					cmd.retype_wr = 1'b1;
					cmd.status    = rtc_pkg::ST_RETYPED;
				end else if (sts.tail_nz && sts.tail_oob) begin
					cmd.status = rtc_pkg::ST_BAD;
				end else if (sts.split_full) begin
					cmd.status = rtc_pkg::ST_FULL;
				end else begin
					cmd.set_status  = 1'b0;
					cmd.shift_begin = 1'b1;
					state_d         = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sts.shift_more) begin
					cmd.shift_step = 1'b1;
				end else begin
					state_d = sts.head_nz ? S_WR_HEAD : S_WR_MID;
				end
			end
			S_WR_HEAD: begin
				cmd.wr_head = 1'b1;
				state_d     = S_WR_MID;
			end
			S_WR_MID: begin
				cmd.wr_mid = 1'b1;
				if (sts.tail_nz) begin
					state_d = S_WR_TAIL;
				end else begin
					cmd.grow       = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = rtc_pkg::ST_SPLIT;
					state_d        = S_RESP;
				end
			end
			S_WR_TAIL: begin
				cmd.wr_tail    = 1'b1;
				cmd.grow       = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = rtc_pkg::ST_SPLIT;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/rtc_dp.sv
// datapath of the region table carve block: request registers, table ram,
// scan compare, shift pipeline and result register
// depends on rtc_pkg and rtc_ram
`default_nettype none

module rtc_dp #(
	parameter int MAX_REGIONS = rtc_pkg::MAX_REGIONS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rtc_pkg::dp_cmd_t                    cmd,
	output rtc_pkg::dp_sts_t                         sts,
	input  wire logic [rtc_pkg::IN_DATA_W-1:0]       in_data,
	input  wire logic [1:0]                          in_user,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [rtc_pkg::OUT_DATA_W-1:0]      out_data,
	output logic      [2:0]                          out_user
);

	localparam int IDX_W = $clog2(MAX_REGIONS);
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int XW    = CNT_W + rtc_pkg::IDX_IN_W;
	localparam int PW    = rtc_pkg::PAGE_W;
	localparam int TW    = rtc_pkg::TYPE_W;
	localparam int EW    = rtc_pkg::ENTRY_W;

	// request
	rtc_pkg::op_t             op_q;
	logic [PW-1:0]            start_q, total_q;
	logic [TW-1:0]            kind_q;
	logic [rtc_pkg::IDX_IN_W-1:0] idx_q;
	logic [PW:0]              rend_q;

	// table and work registers
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] scan_i_q, sptr_q, wp_q;
	logic [PW-1:0]    hit_base_q, hit_pages_q;
	logic [TW-1:0]    hit_kind_q;
	logic [PW:0]      hit_end_q;
	logic             mv_valid_s1;
	logic [IDX_W-1:0] mv_dst_s1;

	// result and output
	rtc_pkg::status_t res_status_q;
	logic [PW-1:0]    res_base_q, res_pages_q;
	logic [TW-1:0]    res_type_q;
	logic             out_valid_q;

	// ram
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0]    ram_wdata, ram_rdata;
	logic [PW-1:0]    rd_base, rd_pages;
	logic [TW-1:0]    rd_kind;
	logic [PW:0]      rd_end;

	logic [CNT_W-1:0] extra;
	logic [CNT_W:0]   grown;
	logic [CNT_W-1:0] nxt_i;
	logic [PW-1:0]    head_len;
	logic [PW:0]      tail_len;
	logic [XW-1:0]    cnt_ext;

	rtc_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_REGIONS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign rd_base  = ram_rdata[PW-1:0];
	assign rd_pages = ram_rdata[2*PW-1:PW];
	assign rd_kind  = ram_rdata[EW-1:2*PW];
	assign rd_end   = {1'b0, rd_base} + {1'b0, rd_pages};

	assign extra    = CNT_W'(sts.head_nz) + CNT_W'(sts.tail_nz);
	assign grown    = {1'b0, count_q} + {1'b0, extra};
	assign nxt_i    = CNT_W'(scan_i_q) + CNT_W'(1);
	assign head_len = start_q - hit_base_q;
	assign tail_len = hit_end_q - rend_q;
	assign cnt_ext  = XW'(count_q);

	always_comb begin
		sts.bad_req     = (op_q == rtc_pkg::OP_UNUSED) ||
		                  ((op_q != rtc_pkg::OP_READ) && (total_q == '0));
		sts.is_append   = (op_q == rtc_pkg::OP_APPEND);
		sts.is_read     = (op_q == rtc_pkg::OP_READ);
		sts.full_append = (count_q >= CNT_W'(MAX_REGIONS));
		sts.idx_ok      = (XW'(idx_q) < cnt_ext);
		sts.count_zero  = (count_q == '0);
		sts.hit         = (rd_base <= start_q) && (rd_end >= rend_q);
		sts.scan_more   = (nxt_i < count_q);
		sts.head_nz     = (start_q != hit_base_q);
		sts.tail_nz     = (hit_end_q != rend_q);
		sts.tail_oob    = rend_q[PW];
		sts.split_full  = (grown > (CNT_W + 1)'(MAX_REGIONS));
		sts.shift_more  = (sptr_q > scan_i_q);
		sts.out_busy    = out_valid_q && !out_ready;
	end

	// read port
	always_comb begin
		ram_re    = cmd.rd_issue | cmd.scan_start | cmd.scan_next | cmd.shift_step;
		ram_raddr = '0;
		priority if (cmd.rd_issue) begin
			ram_raddr = IDX_W'(idx_q);
		end else if (cmd.scan_next) begin
			ram_raddr = scan_i_q + IDX_W'(1);
		end else if (cmd.shift_step) begin
			ram_raddr = sptr_q;
		end else begin
			ram_raddr = '0;
		end
	end

	// write port; a pending move never meets a piece or append write
	always_comb begin
		ram_we    = 1'b1;
		ram_waddr = wp_q;
		ram_wdata = ram_rdata;
		priority if (mv_valid_s1) begin
			ram_waddr = mv_dst_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.append) begin
			ram_waddr = IDX_W'(count_q);
			ram_wdata = rtc_pkg::pack_entry(start_q, total_q, kind_q);
		end else if (cmd.retype_wr) begin
			ram_waddr = scan_i_q;
			ram_wdata = rtc_pkg::pack_entry(hit_base_q, hit_pages_q, kind_q);
		end else if (cmd.wr_head) begin
			ram_wdata = rtc_pkg::pack_entry(hit_base_q, head_len, hit_kind_q);
		end else if (cmd.wr_mid) begin
			ram_wdata = rtc_pkg::pack_entry(start_q, total_q, kind_q);
		end else if (cmd.wr_tail) begin
			ram_wdata = rtc_pkg::pack_entry(rend_q[PW-1:0], tail_len[PW-1:0], hit_kind_q);
		end else begin
			ram_we = 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= rtc_pkg::op_t'(in_user);
			start_q    <= in_data[PW-1:0];
			total_q    <= in_data[2*PW-1:PW];
			kind_q     <= in_data[EW-1:2*PW];
			idx_q      <= in_data[EW+rtc_pkg::IDX_IN_W-1:EW];
			rend_q     <= {1'b0, in_data[PW-1:0]} + {1'b0, in_data[2*PW-1:PW]};
			res_base_q  <= '0;
			res_pages_q <= '0;
			res_type_q  <= '0;
		end
		if (cmd.cap_entry) begin
			res_base_q  <= rd_base;
			res_pages_q <= rd_pages;
			res_type_q  <= rd_kind;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
		end
		if (cmd.scan_start) begin
			scan_i_q <= '0;
		end else if (cmd.scan_next) begin
			scan_i_q <= scan_i_q + IDX_W'(1);
		end
		if (cmd.hit_latch) begin
			hit_base_q  <= rd_base;
			hit_pages_q <= rd_pages;
			hit_kind_q  <= rd_kind;
			hit_end_q   <= rd_end;
		end
		if (cmd.shift_begin) begin
			sptr_q <= IDX_W'(count_q - CNT_W'(1));
		end else if (cmd.shift_step) begin
			sptr_q <= sptr_q - IDX_W'(1);
		end
		if (cmd.shift_begin) begin
			wp_q <= scan_i_q;
		end else if (cmd.wr_head || cmd.wr_mid) begin
			wp_q <= wp_q + IDX_W'(1);
		end
		mv_dst_s1 <= IDX_W'(CNT_W'(sptr_q) + extra);
		if (cmd.publish) begin
			out_user <= res_status_q;
			out_data <= {
				(rtc_pkg::OUT_DATA_W - EW - rtc_pkg::COUNT_OUT_W)'(0),
				cnt_ext[rtc_pkg::COUNT_OUT_W-1:0],
				res_type_q, res_pages_q, res_base_q
			};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			mv_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.grow) begin
				count_q <= grown[CNT_W-1:0];
			end
			mv_valid_s1 <= cmd.shift_step;
			out_valid_q <= cmd.publish | (out_valid_q & ~out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/region_table_carve_core.sv
// top level of the region table carve block
// depends on rtc_pkg, rtc_ctrl, rtc_dp (and rtc_ram below it)
//
// usage
// - one request in on the s_axis group, one response out on the m_axis group
// - s_axis_tuser carries the operation: append, carve or read
// - append puts a region at the end of the table, read returns the region at
//   an index, carve retypes a page range inside the first region holding it,
//   splitting that region and moving later regions up as needed
// - every response carries a status in m_axis_tuser and the region count
// - requests are taken one at a time; s_axis_tready is high only when idle
// - a carve does a scan of one region per cycle, then a move of one region per
//   cycle for every region above the one split, then up to three piece writes
// - these rates are set by the simple dual-port table ram: one read and one
//   write per cycle
// - the response sits in an output register; a stalled receiver holds it, and
//   the block still accepts and works the next request, waiting only to hand
//   over that second response
// - reset clears the region count and the control state; table contents are
//   not cleared and never read before being written
`default_nettype none

module region_table_carve_core #(
	parameter int MAX_REGIONS = rtc_pkg::MAX_REGIONS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [31:0] start_page, [63:32] page_total, [66:64] region_type,
	// [72:67] read_index, [79:73] zero
	input  wire logic [rtc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] operation
	input  wire logic [1:0]                        s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [31:0] entry_base, [63:32] entry_pages, [66:64] entry_type,
	// [73:67] entry_count, [79:74] zero
	output logic      [rtc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// [2:0] status
	output logic      [2:0]                        m_axis_tuser
);

	// controller to datapath commands and status back
	rtc_pkg::dp_cmd_t cmd;
	rtc_pkg::dp_sts_t sts;

	rtc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// request registers, table ram, compare and move logic, result register
	rtc_dp #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);

endmodule

`default_nettype wire

### rtl/rtc_checker.sv
// port-level checker for region_table_carve_core, bound to the top level
// depends on rtc_pkg for the status codes and the data widths
`default_nettype none

module rtc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [rtc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [2:0]                     m_axis_tuser
);

	// stalled response holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled response changed");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= 3'(rtc_pkg::ST_BAD))
		else $error("status code out of range");

	// entry fields are zero when the status is not done; only a successful read sets them
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != 3'(rtc_pkg::ST_DONE)) |->
			m_axis_tdata[rtc_pkg::ENTRY_W-1:0] == '0)
		else $error("entry fields set on a non-read response");

endmodule

bind region_table_carve_core rtc_checker u_rtc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
